### hw/rtl/eae_pkg.sv
// Types and constants for the extended arithmetic element.
package eae_pkg;

  typedef struct packed {
    logic [11:0] func;
    logic [12:0] link_ac;
    logic [11:0] mem_operand;
    logic [23:0] long_operand;
  } eae_in_t;

  typedef struct packed {
    logic [12:0] link_ac_out;
    logic        skip;
    logic [23:0] store_long;
    logic        store_enable;
  } eae_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_NORM,
    ST_SHIFT,
    ST_DONE
  } eae_state_t;

  typedef enum logic [1:0] {
    SH_LEFT,
    SH_ARITH,
    SH_LOGIC
  } shift_kind_t;

  localparam logic [11:0] SWAB_MASK = 12'o7577;
  localparam logic [11:0] SWAB_CODE = 12'o7431;

  // Opcode bits 5,3,2,1 packed as a 5-bit select (bit 4 = opcode bit 5).
  localparam logic [4:0] OP_NOP  = 5'o00;
  localparam logic [4:0] OP_SCL  = 5'o01;
  localparam logic [4:0] OP_MUY  = 5'o02;
  localparam logic [4:0] OP_DVI  = 5'o03;
  localparam logic [4:0] OP_NMI  = 5'o04;
  localparam logic [4:0] OP_SHL  = 5'o05;
  localparam logic [4:0] OP_ASR  = 5'o06;
  localparam logic [4:0] OP_LSR  = 5'o07;
  localparam logic [4:0] OP_SCA  = 5'o20;
  localparam logic [4:0] OP_DAD  = 5'o21;
  localparam logic [4:0] OP_DST  = 5'o22;
  localparam logic [4:0] OP_SWBA = 5'o23;
  localparam logic [4:0] OP_DPSZ = 5'o24;
  localparam logic [4:0] OP_DPIC = 5'o25;
  localparam logic [4:0] OP_DCM  = 5'o26;
  localparam logic [4:0] OP_SAM  = 5'o27;

endpackage

### hw/rtl/extended_arithmetic_element.sv
// Extended arithmetic element top level: sequencer, shared shift/add unit, MQ state.
// One instruction per input beat; in_ready is high only while idle and no result is
// held. Simple instructions pass through a load step and a present step to their result
// beat. Multiply takes 12 shift-add steps, divide 12 restoring subtract steps (a divide
// overflow takes none), normalize up to 24 one-bit shifts, and shifts up to 32 one-bit
// steps, each with a load step before them and finish and present steps after them;
// the iterated steps are one-bit steps of the shared 25-bit shift/add datapath. The
// result beat is held in an output register until taken, and the next input beat is
// accepted at the earliest in the cycle after it leaves. Opcodes are the octal 7xxx
// group three encoding; MQ, the greater-than flag, mode A/B and the step counter
// persist across beats.
module extended_arithmetic_element (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  eae_pkg::eae_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output eae_pkg::eae_out_t out_data
);
  import eae_pkg::*;

  eae_state_t  state, state_next;

  // architectural state
  logic [11:0] mq;
  logic        gtf;
  logic        mode_b;
  logic [4:0]  sc;

  // working registers of the iterative unit
  logic [24:0] acc;        // link:AC:MQ for shifts; AC:MQ for mul/div
  logic [11:0] opnd;       // multiplicand or divisor
  logic [5:0]  cnt;        // remaining steps
  logic [4:0]  nsteps;     // normalize count
  shift_kind_t kind;
  logic        track;
  logic [12:0] link_hi;    // carried link/AC for divide overflow
  logic        sc_zero_end; // shift ends with sc = 0 (mode A) or 037 (mode B)

  eae_out_t    res;
  logic        res_valid;
  logic        accept;

  // ---- decode of the incoming beat (CLA/MQ stage) ----
  logic [11:0] op;
  logic [12:0] la0, la1, la2;
  logic [11:0] mq1;
  logic [4:0]  sel;
  logic        swab;
  logic [11:0] ac1, ac2;
  shift_kind_t sh_kind;
  logic [24:0] sh_acc;
  logic [24:0] dad_sum, dpic_sum, dcm_sum;

  always_comb begin
    op   = in_data.func;
    la0  = in_data.link_ac;
    if (op[7]) la0[11:0] = '0;
    swab = (op & SWAB_MASK) == SWAB_CODE;
    la1  = la0;
    mq1  = mq;
    if (!swab) begin
      case ({op[6], op[4]})
        2'b01: begin mq1 = la0[11:0]; la1[11:0] = '0; end
        2'b10: la1[11:0] = la0[11:0] | mq;
        2'b11: begin mq1 = la0[11:0]; la1[11:0] = mq; end
        default: ;
      endcase
    end
    sel = {op[5], 1'b0, op[3], op[2], op[1]};
    ac1 = la1[11:0];
    // mode A: the SCA bit ORs the step count into AC, except for the SWBA code
    la2 = la1;
    if (!swab && !mode_b && sel[4] && sel != OP_SWBA) la2 = la1 | {8'b0, sc};
    ac2 = la2[11:0];
    case (sel[2:0])
      OP_SHL[2:0]: begin sh_kind = SH_LEFT;  sh_acc = {la2, mq1}; end
      OP_ASR[2:0]: begin sh_kind = SH_ARITH; sh_acc = {ac2[11], ac2, mq1}; end
      default:     begin sh_kind = SH_LOGIC; sh_acc = {1'b0, ac2, mq1}; end
    endcase
    dad_sum  = {1'b0, in_data.long_operand} + {1'b0, ac1, mq1};
    dpic_sum = {1'b0, mq1, ac1} + 25'd1;
    dcm_sum  = {1'b0, ~{mq1, ac1}} + 25'd1;
  end

  // ---- values loaded when a beat is accepted ----
  eae_state_t  ld_state;
  eae_out_t    ld_res;
  logic [11:0] ld_mq;
  logic [4:0]  ld_sc;
  logic        ld_gtf;
  logic        ld_mode_b;
  logic        ld_track;
  logic        ld_sc_zero_end;
  shift_kind_t ld_kind;
  logic [24:0] ld_acc;
  logic [5:0]  ld_cnt;

  always_comb begin
    ld_state           = ST_DONE;
    ld_res             = '0;
    ld_res.link_ac_out = la2;
    ld_mq              = mq1;
    ld_sc              = sc;
    ld_gtf             = gtf;
    ld_mode_b          = mode_b;
    ld_track           = 1'b0;
    ld_sc_zero_end     = 1'b0;
    ld_kind            = SH_LEFT;
    ld_acc             = {1'b0, ac2, mq1};
    ld_cnt             = 6'd12;
    if (swab) begin
      ld_mode_b = 1'b1;
    end else if (!mode_b) begin
      case (sel[2:0])
        OP_SCL[2:0]: begin
          ld_sc = ~in_data.mem_operand[4:0];
          ld_res.skip = 1'b1;
        end
        OP_MUY[2:0]: ld_state = ST_MUL;
        OP_DVI[2:0]: if (sel == OP_DVI) ld_state = ST_DIV;
        OP_NMI[2:0]: begin
          ld_acc = {la2, mq1}; ld_cnt = 6'd24; ld_state = ST_NORM;
        end
        OP_SHL[2:0], OP_ASR[2:0], OP_LSR[2:0]: begin
          ld_kind = sh_kind;
          ld_acc = sh_acc;
          ld_cnt = {1'b0, in_data.mem_operand[4:0]} + 6'd1;
          ld_sc_zero_end = 1'b1;
          ld_state = ST_SHIFT;
        end
        default: ;
      endcase
    end else begin
      case (sel)
        OP_SCL: begin ld_sc = ac1[4:0]; ld_res.link_ac_out = {la1[12], 12'b0}; end
        OP_MUY: ld_state = ST_MUL;
        OP_DVI: ld_state = ST_DIV;
        OP_NMI: begin ld_acc = {la1, mq1}; ld_cnt = 6'd24; ld_state = ST_NORM; end
        OP_SHL, OP_ASR, OP_LSR: begin
          ld_kind = sh_kind;
          ld_track = sel != OP_SHL;
          ld_acc = sh_acc;
          ld_cnt = {1'b0, in_data.mem_operand[4:0]};
          ld_state = ST_SHIFT;
        end
        OP_SCA: ld_res.link_ac_out = la1 | {8'b0, sc};
        OP_DAD: begin
          ld_mq = dad_sum[11:0];
          ld_res.link_ac_out = dad_sum[24:12];
          ld_res.skip = 1'b1;
        end
        OP_DST: begin
          ld_res.store_long = {ac1, mq1};
          ld_res.store_enable = 1'b1;
          ld_res.skip = 1'b1;
        end
        OP_SWBA: begin ld_gtf = 1'b0; ld_mode_b = 1'b0; end
        OP_DPSZ: if (ac1 == 12'd0 && mq1 == 12'd0) ld_res.skip = 1'b1;
        OP_DPIC: begin
          ld_mq = dpic_sum[11:0];
          ld_res.link_ac_out = dpic_sum[24:12];
        end
        OP_DCM: begin
          ld_mq = dcm_sum[11:0];
          ld_res.link_ac_out = dcm_sum[24:12];
        end
        OP_SAM: begin
          if (mq1[11] != ac1[11]) ld_gtf = ac1[11];
          else ld_gtf = mq1 >= ac1;
          ld_res.link_ac_out = ({1'b0, mq1} - {1'b0, ac1}) ^ 13'o10000;
        end
        default: ;
      endcase
    end
  end

  // ---- one-bit step of the shared unit ----
  logic [24:0] step_acc;
  logic        step_gtf;
  logic [12:0] mul_sum;
  logic [24:0] dvd25;
  logic        div_ovf;
  logic        norm_stop;

  // acc = {carry, AC, MQ}; add multiplicand to AC when MQ lsb set, then shift right
  assign mul_sum = {1'b0, acc[23:12]} + {1'b0, opnd};
  // divide overflow is checked once, before the first restoring step
  assign div_ovf = (cnt == 6'd12) && (acc[23:12] >= opnd);
  assign norm_stop = cnt == 6'd0 || acc[23:0] == 24'o60000000 ||
                     acc[23:22] == 2'b10 || acc[23:22] == 2'b01 || acc[23:0] == 24'd0;

  always_comb begin
    dvd25    = {acc[23:0], 1'b0};
    step_acc = acc;
    step_gtf = gtf;
    case (state)
      ST_MUL: step_acc = acc[0] ? {1'b0, mul_sum, acc[11:1]} : {1'b0, acc[24:1]};
      ST_DIV: begin
        // restoring: shift AC:MQ left, trial subtract divisor, quotient bit into MQ
        if (dvd25[24:12] >= {1'b0, opnd})
          step_acc = {dvd25[24:12] - {1'b0, opnd}, dvd25[11:1], 1'b1};
        else
          step_acc = {1'b0, dvd25[23:1], 1'b0};
      end
      ST_NORM: step_acc = {acc[23:0], 1'b0};
      ST_SHIFT: begin
        if (track) step_gtf = acc[0];
        case (kind)
          SH_LEFT:  step_acc = {acc[23:0], 1'b0};
          SH_ARITH: step_acc = {acc[24], acc[24:1]};
          default:  step_acc = {1'b0, acc[24:1]};
        endcase
      end
      default: ;
    endcase
  end

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ld_state;
      ST_MUL, ST_SHIFT: if (cnt == 6'd0) state_next = ST_DONE;
      ST_DIV:   if (cnt == 6'd0 || div_ovf) state_next = ST_DONE;
      ST_NORM:  if (norm_stop) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign in_ready  = (state == ST_IDLE) && !res_valid;
  assign accept    = in_valid && in_ready;
  assign out_valid = res_valid;
  assign out_data  = res;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mq <= '0; gtf <= 1'b0; mode_b <= 1'b0; sc <= '0;
      res_valid <= 1'b0; cnt <= '0;
    end else begin
      if (state == ST_DONE) res_valid <= 1'b1;
      else if (out_ready)   res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res         <= ld_res;
            mq          <= ld_mq;
            sc          <= ld_sc;
            gtf         <= ld_gtf;
            mode_b      <= ld_mode_b;
            acc         <= ld_acc;
            cnt         <= ld_cnt;
            nsteps      <= '0;
            opnd        <= in_data.mem_operand;
            link_hi     <= la2;
            kind        <= ld_kind;
            track       <= ld_track;
            sc_zero_end <= ld_sc_zero_end;
          end
        end
        ST_MUL: begin
          if (cnt == 6'd0) begin
            mq <= acc[11:0];
            res.link_ac_out <= {1'b0, acc[23:12]};
            res.skip <= 1'b1;
          end else begin
            acc <= step_acc;
            cnt <= cnt - 6'd1;
          end
        end
        ST_DIV: begin
          if (div_ovf) begin
            res.skip <= 1'b1;
            if (acc[23:0] == {opnd, 12'd0}) begin
              mq <= 12'd1;
              res.link_ac_out <= {1'b1, opnd};
            end else begin
              mq <= {acc[10:0], 1'b1};
              res.link_ac_out <= {1'b1, link_hi[11:0]};
            end
          end else if (cnt == 6'd0) begin
            mq <= acc[11:0];
            res.link_ac_out <= {1'b0, acc[23:12]};
            res.skip <= 1'b1;
          end else begin
            acc <= step_acc;
            cnt <= cnt - 6'd1;
          end
        end
        ST_NORM: begin
          if (norm_stop) begin
            sc <= nsteps;
            if (mode_b && acc[23:0] == 24'o40000000) begin
              mq <= '0;
              res.link_ac_out <= {acc[24], 12'd0};
            end else begin
              mq <= acc[11:0];
              res.link_ac_out <= acc[24:12];
            end
          end else begin
            acc <= step_acc;
            nsteps <= nsteps + 5'd1;
            cnt <= cnt - 6'd1;
          end
        end
        ST_SHIFT: begin
          if (cnt == 6'd0) begin
            mq <= acc[11:0];
            res.link_ac_out <= acc[24:12];
            res.skip <= 1'b1;
            sc <= sc_zero_end ? 5'd0 : 5'o37;
          end else begin
            acc <= step_acc;
            gtf <= step_gtf;
            cnt <= cnt - 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // result never presented while a new beat can be taken
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("result overlaps input");
  // a finished instruction always raises out_valid next cycle
  assert property (@(posedge clk) disable iff (rst) state == ST_DONE |=> out_valid)
    else $error("result lost");
  // step counter of busy loops never exceeds the longest shift
  assert property (@(posedge clk) disable iff (rst) state == ST_SHIFT |-> cnt <= 6'd32)
    else $error("shift count overrun");
  // store only for a double store beat, which always skips
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.store_enable |-> out_data.skip)
    else $error("store without skip");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the extended arithmetic element.
module tb_top;
  import eae_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  eae_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  eae_out_t out_data;

  extended_arithmetic_element dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [11:0] mq;
  logic        gt;
  logic        modeb;
  logic [4:0]  sc;

  eae_in_t  pending_beats[$];
  eae_out_t expected_results[$];
  int       errors = 0;
  int       hold_off = 0;
  int       in_gap = 0;
  int       out_gap = 0;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [25:0] do_mul(logic [25:0] la, logic [11:0] m);
    logic [31:0] p;
    p = m * mq + la[11:0];
    mq = p[11:0];
    return {1'b1, p[24:12]};
  endfunction

  function automatic logic [25:0] do_div(logic [25:0] la, logic [11:0] d);
    logic [23:0] dvd;
    dvd = {la[11:0], mq};
    if (dvd[23:12] < d) begin
      mq = 12'(dvd / d);
      return {13'h1000, 1'b0, 12'(dvd % d)} | 26'h2000;
    end
    if (dvd == {d, 12'd0}) begin
      mq = 12'd1;
      return {12'd0, 2'b11, d};
    end
    mq = {mq[10:0], 1'b1};
    return la | 26'h3000;
  endfunction

  function automatic logic [25:0] do_norm(logic [25:0] la);
    logic [24:0] a;
    int n;
    a = {la[12:0], mq};
    n = 0;
    while (a[23:0] != 0 && n < 24) begin
      if (a[23:0] == 24'o60000000) break;
      if (a[23:22] == 2'b10 || a[23:22] == 2'b01) break;
      n++;
      a = {a[23:0], 1'b0};
    end
    sc = n[4:0];
    if (modeb && a[23:0] == 24'o40000000) a = a & 25'h1000000;
    mq = a[11:0];
    return {13'd0, a[24:12]};
  endfunction

  function automatic logic [25:0] do_shift(logic [25:0] la, shift_kind_t kind, int cnt,
                                           bit track);
    logic [24:0] a;
    if (kind == SH_LEFT) a = {la[12:0], mq};
    else if (kind == SH_ARITH) a = {la[11], la[11:0], mq};
    else a = {1'b0, la[11:0], mq};
    for (int i = 0; i < cnt; i++) begin
      if (track) gt = a[0];
      if (kind == SH_LEFT) a = {a[23:0], 1'b0};
      else if (kind == SH_ARITH) a = {a[24], a[24:1]};
      else a = {1'b0, a[24:1]};
    end
    mq = a[11:0];
    return {1'b1, a[24:12]};
  endfunction

  // bit 13 of the working word is the skip flag
  function automatic eae_out_t predict_result(eae_in_t b);
    logic [25:0] la;
    logic [11:0] w, ac, t;
    logic [4:0]  sel;
    logic [24:0] a;
    eae_out_t r;
    r = '0;
    la = {13'd0, b.link_ac};
    w = b.mem_operand;
    if (b.func[7]) la[11:0] = '0;
    if ((b.func & SWAB_MASK) == SWAB_CODE) begin
      modeb = 1'b1;
    end else begin
      case ({b.func[6], b.func[4]})
        2'b01: begin mq = la[11:0]; la[11:0] = '0; end
        2'b10: la[11:0] = la[11:0] | mq;
        2'b11: begin t = mq; mq = la[11:0]; la[11:0] = t; end
        default: ;
      endcase
      sel = {b.func[5], 1'b0, b.func[3:1]};
      ac = la[11:0];
      if (!modeb) begin
        if (sel[4] && sel != OP_SWBA) la[4:0] = la[4:0] | sc;
        case (sel[2:0])
          OP_SCL[2:0]: begin sc = ~w[4:0]; la[13] = 1'b1; end
          OP_MUY[2:0]: la = do_mul(la, w);
          OP_DVI[2:0]: if (sel == OP_DVI) la = do_div(la, w);
          OP_NMI[2:0]: la = do_norm(la);
          OP_SHL[2:0]: begin la = do_shift(la, SH_LEFT, w[4:0] + 1, 0); sc = 0; end
          OP_ASR[2:0]: begin la = do_shift(la, SH_ARITH, w[4:0] + 1, 0); sc = 0; end
          OP_LSR[2:0]: begin la = do_shift(la, SH_LOGIC, w[4:0] + 1, 0); sc = 0; end
          default: ;
        endcase
      end else begin
        case (sel)
          OP_SCL: begin sc = ac[4:0]; la = la & 26'h1000; end
          OP_MUY: la = do_mul(la, w);
          OP_DVI: la = do_div(la, w);
          OP_NMI: la = do_norm(la);
          OP_SHL: begin la = do_shift(la, SH_LEFT, w[4:0], 0); sc = 5'h1f; end
          OP_ASR: begin la = do_shift(la, SH_ARITH, w[4:0], 1); sc = 5'h1f; end
          OP_LSR: begin la = do_shift(la, SH_LOGIC, w[4:0], 1); sc = 5'h1f; end
          OP_SCA: la[4:0] = la[4:0] | sc;
          OP_DAD: begin
            a = b.long_operand + {ac, mq};
            mq = a[11:0];
            la = {1'b1, a[24:12]};
          end
          OP_DST: begin
            r.store_long = {ac, mq};
            r.store_enable = 1'b1;
            la[13] = 1'b1;
          end
          OP_SWBA: begin gt = 0; modeb = 0; end
          OP_DPSZ: if (ac == 0 && mq == 0) la[13] = 1'b1;
          OP_DPIC: begin
            a = {mq, ac} + 1;
            mq = a[11:0];
            la = {13'd0, a[24:12]};
          end
          OP_DCM: begin
            a = ({1'b0, mq, ac} ^ 25'hffffff) + 1;
            mq = a[11:0];
            la = {13'd0, a[24:12]};
          end
          OP_SAM: begin
            if (mq[11] != ac[11]) gt = ac[11];
            else gt = (mq >= ac);
            la = {13'd0, 13'(mq - ac) ^ 13'h1000};
          end
          default: ;
        endcase
      end
    end
    r.link_ac_out = la[12:0];
    r.skip = la[13];
    return r;
  endfunction

  // driver: present the oldest pending beat, with random gaps between beats
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_result(in_data));
        void'(pending_beats.pop_front());
        in_gap = rand_gap();
      end
      if ((!in_valid || in_ready) ) begin
        if (in_gap > 0) in_gap--;
        if (in_gap == 0 && pending_beats.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_beats[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          if (out_data.link_ac_out !== expected_results[0].link_ac_out)
            $display("%0t: link_ac_out exp %o got %o", $time,
                     expected_results[0].link_ac_out, out_data.link_ac_out);
          if (out_data.skip !== expected_results[0].skip)
            $display("%0t: skip exp %b got %b", $time, expected_results[0].skip,
                     out_data.skip);
          if (out_data.store_long !== expected_results[0].store_long)
            $display("%0t: store_long exp %o got %o", $time,
                     expected_results[0].store_long, out_data.store_long);
          if (out_data.store_enable !== expected_results[0].store_enable)
            $display("%0t: store_enable exp %b got %b", $time,
                     expected_results[0].store_enable, out_data.store_enable);
          if (out_data !== expected_results[0]) errors++;
          void'(expected_results.pop_front());
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = rand_gap();
      end
    end
  end

  function automatic eae_in_t make_beat(logic [11:0] f);
    eae_in_t b;
    b.func = f;
    b.link_ac = 13'($urandom);
    b.mem_operand = 12'($urandom);
    b.long_operand = 24'($urandom);
    return b;
  endfunction

  // mode-B biased opcode: group three with MQ bits and a random select
  function automatic logic [11:0] rand_eae_func();
    logic [11:0] f;
    f = 12'o7401 | 12'($urandom_range(0, 511) << 1);
    if ($urandom_range(0, 9) == 0) f = 12'($urandom);
    return f;
  endfunction

  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    eae_in_t b;
    mq = 0; gt = 0; modeb = 0; sc = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes of fields and each select in both modes
    b = '0; b.func = 12'o7401; pending_beats.push_back(b);
    b = '1; pending_beats.push_back(b);
    for (int m = 0; m < 2; m++) begin
      if (m == 1) pending_beats.push_back(make_beat(SWAB_CODE));
      for (int s = 0; s < 16; s++) begin
        b = make_beat(12'o7401 | 12'(s[3] << 5) | 12'(s[2:0] << 1) | 12'o0020);
        if (s == 3) begin b.link_ac = 13'o0; b.mem_operand = 12'o0; end
        if (s == 11 && m == 1) continue;
        pending_beats.push_back(b);
      end
    end
    // divide overflow: AC:MQ equal to divisor:0 (MQ loaded with 0 by MQL)
    b = make_beat(12'o7421); b.link_ac = 13'o0; pending_beats.push_back(b);
    b = make_beat(12'o7407); b.link_ac = 13'o1234; b.mem_operand = 12'o1234;
    pending_beats.push_back(b);
    pending_beats.push_back(make_beat(12'o7447));   // SWBA back to mode A
    wait_drained();
    // long receiver stall while the sender keeps offering
    for (int i = 0; i < 30; i++) pending_beats.push_back(make_beat(rand_eae_func()));
    hold_off = 400;
    wait_drained();
    for (int i = 0; i < 1300; i++) begin
      if ($urandom_range(0, 19) == 0) b = make_beat(SWAB_CODE);
      else if ($urandom_range(0, 29) == 0) b = make_beat(12'o7447);
      else b = make_beat(rand_eae_func());
      pending_beats.push_back(b);
      // sender pauses until every outstanding result has come back
      if (i == 650) wait_drained();
    end
    wait_drained();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
